// File: sv/ivm_pkg.sv
// Shared types, codes and defaults of the interval value map.
`timescale 1ns / 1ps
package ivm_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 32;
  localparam logic [7:0] DEFAULT_RESET = 8'd65;

  localparam int ADDR_BITS = 3;
  localparam logic REG_DEFAULT_VALUE = 1'b0;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_DEL,
    S_INS_E,
    S_INS_B,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic decide;
    logic del;
    logic ins_e;
    logic ins_b;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic reject;
    logic region_nz;
    logic ins_b;
    logic ins_e;
  } dp_stat_t;

endpackage

// File: sv/ivm_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface ivm_req_if #(
  parameter int KEY_BITS = ivm_pkg::DEF_KEY_BITS
);
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [KEY_BITS-1:0] key_begin;
  logic signed [KEY_BITS-1:0] key_end;
  logic [7:0]                 new_value;
  logic signed [KEY_BITS-1:0] query_key;

  modport source (output valid, cmd, key_begin, key_end, new_value, query_key, input ready);
  modport sink (input valid, cmd, key_begin, key_end, new_value, query_key, output ready);
endinterface

interface ivm_rsp_if #(
  parameter int CNT_BITS = $clog2(ivm_pkg::DEF_CAPACITY + 1)
);
  logic                valid;
  logic                ready;
  logic [7:0]          read_value;
  logic [1:0]          status;
  logic [CNT_BITS-1:0] entries_used;

  modport source (output valid, read_value, status, entries_used, input ready);
  modport sink (input valid, read_value, status, entries_used, output ready);
endinterface

// File: sv/interval_value_map.sv
// Top level of the interval value map.
`timescale 1ns / 1ps
// Sorted breakpoint table of CAPACITY cells mapping signed keys to 8-bit values; one request
// at a time, one result each. For a lookup, every cell compares its key in parallel and the
// flags are registered, then the last matching cell's value is selected into the result
// register. An assign evaluates, decides, then removes the d breakpoints the interval covers
// (one cell shift left per removed breakpoint) and inserts i (0 to 2) breakpoints (one shift
// right each); an empty assign skips both and a rejected one leaves the table unchanged.
// Writing default_value at address 0 resets the table to a single breakpoint.
module interval_value_map #(
  parameter int CAPACITY = ivm_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = ivm_pkg::DEF_KEY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  ivm_req_if.sink                       in,
  ivm_rsp_if.source                     out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ivm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW = $clog2(CAPACITY + 1);

  ivm_pkg::dp_cmd_t  cmd;
  ivm_pkg::dp_stat_t stat;
  logic              cfg_wr;
  logic [7:0]        default_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ivm_pkg::REG_DEFAULT_VALUE);
  assign prdata = (paddr[2] == ivm_pkg::REG_DEFAULT_VALUE) ? {24'd0, default_value} : 32'd0;

  ivm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ivm_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .CW       (CW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_wr),
    .cfg_data      (pwdata[7:0]),
    .default_value (default_value),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in.cmd),
    .in_key_begin  (in.key_begin),
    .in_key_end    (in.key_end),
    .in_new_value  (in.new_value),
    .in_query_key  (in.query_key),
    .read_value    (out.read_value),
    .status        (out.status),
    .entries_used  (out.entries_used)
  );

endmodule

// File: sv/ivm_ctrl.sv
// Sequencer of the interval value map.
`timescale 1ns / 1ps
module ivm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ivm_pkg::dp_stat_t stat,
  output ivm_pkg::dp_cmd_t  cmd
);

  ivm_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ivm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ivm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ivm_pkg::S_IDLE: begin
        if (in_valid) state_next = ivm_pkg::S_EVAL;
      end
      ivm_pkg::S_EVAL: begin
        if (stat.is_lookup || stat.empty) state_next = ivm_pkg::S_FINISH;
        else state_next = ivm_pkg::S_DECIDE;
      end
      ivm_pkg::S_DECIDE: state_next = ivm_pkg::S_DEL;
      ivm_pkg::S_DEL: begin
        priority if (stat.reject) state_next = ivm_pkg::S_FINISH;
        else if (stat.region_nz) state_next = ivm_pkg::S_DEL;
        else if (stat.ins_e) state_next = ivm_pkg::S_INS_E;
        else if (stat.ins_b) state_next = ivm_pkg::S_INS_B;
        else state_next = ivm_pkg::S_FINISH;
      end
      ivm_pkg::S_INS_E: begin
        if (stat.ins_b) state_next = ivm_pkg::S_INS_B;
        else state_next = ivm_pkg::S_FINISH;
      end
      ivm_pkg::S_INS_B: state_next = ivm_pkg::S_FINISH;
      ivm_pkg::S_FINISH: begin
        if (out_free) state_next = ivm_pkg::S_IDLE;
      end
      default: state_next = ivm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ivm_pkg::S_IDLE:   cmd.capture = in_valid;
      ivm_pkg::S_EVAL:   cmd.eval = 1'b1;
      ivm_pkg::S_DECIDE: cmd.decide = 1'b1;
      ivm_pkg::S_DEL:    cmd.del = !stat.reject && stat.region_nz;
      ivm_pkg::S_INS_E:  cmd.ins_e = 1'b1;
      ivm_pkg::S_INS_B:  cmd.ins_b = 1'b1;
      ivm_pkg::S_FINISH: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/ivm_dp.sv
// Breakpoint cells, compare flags and result register.
`timescale 1ns / 1ps
module ivm_dp #(
  parameter int CAPACITY = ivm_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = ivm_pkg::DEF_KEY_BITS,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr,
  input  logic [7:0]                 cfg_data,
  output logic [7:0]                 default_value,
  input  ivm_pkg::dp_cmd_t           cmd,
  output ivm_pkg::dp_stat_t          stat,
  input  logic                       in_cmd,
  input  logic signed [KEY_BITS-1:0] in_key_begin,
  input  logic signed [KEY_BITS-1:0] in_key_end,
  input  logic [7:0]                 in_new_value,
  input  logic signed [KEY_BITS-1:0] in_query_key,
  output logic [7:0]                 read_value,
  output logic [1:0]                 status,
  output logic [CW-1:0]              entries_used
);

  localparam logic [KEY_BITS-1:0] MIN_KEY = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic                       op;
  logic signed [KEY_BITS-1:0] kb, ke, qk;
  logic [7:0]                 nv;

  logic signed [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [7:0]                 cell_val [CAPACITY];
  logic signed [KEY_BITS-1:0] key_up [CAPACITY];
  logic signed [KEY_BITS-1:0] key_dn [CAPACITY];
  logic [7:0]                 val_up [CAPACITY];
  logic [7:0]                 val_dn [CAPACITY];
  logic [CAPACITY-1:0]        valid, ltb, lee, leq;
  logic [CAPACITY-1:0]        region, sel_b, sel_a, sel_q, lo_hot;
  logic [CW-1:0]              cnt;

  logic [7:0] before_v, after_v, query_v, after_r;
  logic       ins_b_c, ins_e_c, ins_b_r, ins_e_r, reject_r, reject_c;
  logic       empty;
  logic [1:0] k_rm, need;
  logic [CW:0] free;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_nbr
      if (g < CAPACITY - 1) begin : g_up
        assign key_up[g] = cell_key[g+1];
        assign val_up[g] = cell_val[g+1];
      end else begin : g_top
        assign key_up[g] = '0;
        assign val_up[g] = '0;
      end
      if (g > 0) begin : g_dn
        assign key_dn[g] = cell_key[g-1];
        assign val_dn[g] = cell_val[g-1];
      end else begin : g_bot
        assign key_dn[g] = '0;
        assign val_dn[g] = '0;
      end
    end
  endgenerate

  assign region = lee & ~ltb;
  assign sel_b  = ltb & ~(ltb >> 1);
  assign sel_a  = lee & ~(lee >> 1);
  assign sel_q  = leq & ~(leq >> 1);
  assign lo_hot = ~ltb & {ltb[CAPACITY-2:0], 1'b1};

  always_comb begin
    before_v = '0;
    after_v  = '0;
    query_v  = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      before_v = before_v | (sel_b[j] ? cell_val[j] : 8'd0);
      after_v  = after_v | (sel_a[j] ? cell_val[j] : 8'd0);
      query_v  = query_v | (sel_q[j] ? cell_val[j] : 8'd0);
    end
  end

  assign ins_b_c = !ltb[0] || (before_v != nv);
  assign ins_e_c = after_v != nv;
  assign empty   = !(kb < ke);

  always_comb begin
    if (region == '0) k_rm = 2'd0;
    else if ((region & (region - 1'b1)) == '0) k_rm = 2'd1;
    else k_rm = 2'd2;
  end

  assign need     = {1'b0, ins_b_c} + {1'b0, ins_e_c};
  assign free     = (CW+1)'(CAPACITY) - {1'b0, cnt};
  assign reject_c = (CW+1)'(need) > free + (CW+1)'(k_rm);

  assign stat.is_lookup = (op == ivm_pkg::CMD_LOOKUP);
  assign stat.empty     = empty;
  assign stat.reject    = reject_r;
  assign stat.region_nz = (region != '0);
  assign stat.ins_b     = ins_b_r;
  assign stat.ins_e     = ins_e_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= ivm_pkg::DEFAULT_RESET;
    end else if (cfg_wr) begin
      default_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_cmd;
      kb <= in_key_begin;
      ke <= in_key_end;
      nv <= in_new_value;
      qk <= in_query_key;
    end
    if (cmd.decide) begin
      ins_b_r  <= ins_b_c;
      ins_e_r  <= ins_e_c;
      after_r  <= after_v;
      reject_r <= reject_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      for (int j = 0; j < CAPACITY; j++) begin
        ltb[j] <= valid[j] && (cell_key[j] < kb);
        lee[j] <= valid[j] && (cell_key[j] <= ke);
        leq[j] <= valid[j] && (cell_key[j] <= qk);
      end
    end else if (cmd.del) begin
      lee <= lee >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      valid       <= CAPACITY'(1);
      cnt         <= CW'(1);
      cell_key[0] <= MIN_KEY;
      cell_val[0] <= rst ? ivm_pkg::DEFAULT_RESET : cfg_data;
    end else if (cmd.del) begin
      valid <= (valid & ltb) | ((valid >> 1) & ~ltb);
      cnt   <= cnt - 1'b1;
      for (int j = 0; j < CAPACITY; j++) begin
        if (!ltb[j]) begin
          cell_key[j] <= key_up[j];
          cell_val[j] <= val_up[j];
        end
      end
    end else if (cmd.ins_e || cmd.ins_b) begin
      valid <= (valid & ltb) | lo_hot | ((valid << 1) & ~ltb);
      cnt   <= cnt + 1'b1;
      for (int j = 0; j < CAPACITY; j++) begin
        if (lo_hot[j]) begin
          cell_key[j] <= cmd.ins_e ? ke : kb;
          cell_val[j] <= cmd.ins_e ? after_r : nv;
        end else if (!ltb[j]) begin
          cell_key[j] <= key_dn[j];
          cell_val[j] <= val_dn[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entries_used <= cnt;
      if (op == ivm_pkg::CMD_LOOKUP) begin
        read_value <= query_v;
        status     <= ivm_pkg::ST_DONE;
      end else begin
        read_value <= '0;
        priority if (empty) status <= ivm_pkg::ST_EMPTY;
        else if (reject_r) status <= ivm_pkg::ST_FULL;
        else status <= ivm_pkg::ST_DONE;
      end
    end
  end

endmodule

// File: sv/ivm_chk.sv
// Port-level checks of the interval value map, bound to the top level.
`timescale 1ns / 1ps
module ivm_chk #(
  parameter int CAPACITY = ivm_pkg::DEF_CAPACITY,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    status,
  input logic [CW-1:0] entries_used
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ivm_pkg::ST_DONE || status == ivm_pkg::ST_EMPTY ||
                   status == ivm_pkg::ST_FULL))
    else $error("bad status code");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entries_used != '0 && entries_used <= CW'(CAPACITY)))
    else $error("entry count out of range");

endmodule

bind interval_value_map ivm_chk #(
  .CAPACITY (CAPACITY)
) u_ivm_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in.valid),
  .in_ready     (in.ready),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .status       (out.status),
  .entries_used (out.entries_used)
);

// File: tb/sv/ivm_checker.sv
// Checker for the interval value map: table predictor and result comparison.
`timescale 1ns / 1ps
module ivm_checker (
  input  logic        clk,
  input  logic        rst,
  ivm_req_if.sink     req,
  ivm_rsp_if.sink     rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ivm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
    logic [6:0] entries_used;
  } map_result_t;

  localparam int CAP = ivm_pkg::DEF_CAPACITY;

  logic [31:0] tbl_key [CAP];
  logic [7:0]  tbl_val [CAP];
  int          tbl_cnt;
  logic [7:0]  base_value;
  map_result_t expected_q[$];

  function automatic logic [31:0] biased(logic [31:0] k);
    return k ^ 32'h8000_0000;
  endfunction

  function automatic void reinit(logic [7:0] dv);
    base_value = dv;
    tbl_key[0] = '0;
    tbl_val[0] = dv;
    tbl_cnt = 1;
  endfunction

  function automatic map_result_t apply_request(logic c, logic [31:0] kb, logic [31:0] ke,
                                                logic [7:0] nv, logic [31:0] qk);
    map_result_t r;
    logic [31:0] b, e, q;
    logic [31:0] nk [CAP];
    logic [7:0] nvv [CAP];
    int i, lo, hi, newc, n;
    logic [7:0] bef, aft;
    bit has_b, ins_b, ins_e;
    r = '0;
    if (c == ivm_pkg::CMD_LOOKUP) begin
      q = biased(qk);
      i = 0;
      while (i + 1 < tbl_cnt && tbl_key[i+1] <= q) i++;
      r.read_value = tbl_val[i];
    end else begin
      b = biased(kb);
      e = biased(ke);
      if (!(b < e)) begin
        r.status = ivm_pkg::ST_EMPTY;
      end else begin
        lo = 0;
        while (lo < tbl_cnt && tbl_key[lo] < b) lo++;
        hi = lo;
        while (hi < tbl_cnt && tbl_key[hi] <= e) hi++;
        has_b = lo > 0;
        bef = has_b ? tbl_val[lo-1] : 8'd0;
        aft = (hi > lo) ? tbl_val[hi-1] : bef;
        ins_e = aft != nv;
        ins_b = !has_b || bef != nv;
        newc = tbl_cnt - (hi - lo) + ins_b + ins_e;
        if (newc > CAP) begin
          r.status = ivm_pkg::ST_FULL;
        end else begin
          n = 0;
          for (i = 0; i < lo; i++) begin nk[n] = tbl_key[i]; nvv[n] = tbl_val[i]; n++; end
          if (ins_b) begin nk[n] = b; nvv[n] = nv; n++; end
          if (ins_e) begin nk[n] = e; nvv[n] = aft; n++; end
          for (i = hi; i < tbl_cnt; i++) begin nk[n] = tbl_key[i]; nvv[n] = tbl_val[i]; n++; end
          for (i = 0; i < n; i++) begin tbl_key[i] = nk[i]; tbl_val[i] = nvv[i]; end
          tbl_cnt = newc;
        end
      end
    end
    r.entries_used = tbl_cnt[6:0];
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    reinit(ivm_pkg::DEFAULT_RESET);
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    map_result_t w;
    if (rst) begin
      reinit(ivm_pkg::DEFAULT_RESET);
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && paddr == {ivm_pkg::ADDR_BITS{1'b0}})
        reinit(pwdata[7:0]);
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(req.cmd, req.key_begin, req.key_end,
                                           req.new_value, req.query_key));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          w = expected_q.pop_front();
          if (rsp.read_value !== w.read_value) report("read_value", rsp.read_value, w.read_value);
          if (rsp.status !== w.status) report("status", rsp.status, w.status);
          if (rsp.entries_used !== w.entries_used)
            report("entries_used", rsp.entries_used, w.entries_used);
        end
      end
    end
  end
endmodule

// File: tb/sv/interval_value_map_tb.sv
// Testbench top: stimulus, configuration and verdict for the interval value map.
`timescale 1ns / 1ps
module interval_value_map_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ivm_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int cycles = 0;
  bit stall_mode = 1'b0;

  ivm_req_if req_ch ();
  ivm_rsp_if rsp_ch ();

  interval_value_map u_top (
    .clk(clk), .rst(rst), .in(req_ch.sink), .out(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ivm_checker u_chk (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.sink),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0; req_ch.cmd = ivm_pkg::CMD_LOOKUP; req_ch.key_begin = '0;
    req_ch.key_end = '0; req_ch.new_value = '0; req_ch.query_key = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("interval_value_map regression: fail");
      $finish;
    end
  end

  // receiver stall pattern: phases of free flow and of random stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    if (stall_mode) rsp_ch.ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
    else rsp_ch.ready <= 1'b1;
  end

  task automatic send_req(logic c, logic [31:0] kb, logic [31:0] ke, logic [7:0] nv,
                          logic [31:0] qk);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.key_begin <= kb;
    req_ch.key_end <= ke;
    req_ch.new_value <= nv;
    req_ch.query_key <= qk;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic idle_bus();
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    idle_bus();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_default(logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ivm_pkg::REG_DEFAULT_VALUE; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_key(int span);
    if (span == 0) return $urandom();
    return 32'($signed($urandom_range(0, span)) - span / 2);
  endfunction

  task automatic random_phase(int count, int span);
    int burst;
    logic [31:0] a, b;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        a = rand_key(span);
        b = ($urandom_range(0, 9) == 0) ? rand_key(span) : a + $urandom_range(1, span + 3);
        if ($urandom_range(0, 1))
          send_req(ivm_pkg::CMD_ASSIGN, a, b,
                   8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)), $urandom);
        else
          send_req(ivm_pkg::CMD_LOOKUP, $urandom, $urandom, $urandom, rand_key(span));
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_bus();
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 32'h8000_0000);
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 32'h7fff_ffff);
    send_req(ivm_pkg::CMD_ASSIGN, 10, 10, 8'd5, 0);
    send_req(ivm_pkg::CMD_ASSIGN, 20, 10, 8'd5, 0);
    send_req(ivm_pkg::CMD_ASSIGN, 32'h8000_0000, 0, 8'd7, 0);
    send_req(ivm_pkg::CMD_ASSIGN, 0, 32'h7fff_ffff, 8'hff, 0);
    send_req(ivm_pkg::CMD_ASSIGN, 32'hffff_fff0, 32'h10, 8'd0, 32'hffff_ffff);
    send_req(ivm_pkg::CMD_ASSIGN, 5, 6, 8'd7, 0);
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 5);
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 6);
    send_req(ivm_pkg::CMD_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 8'hff, 32'hffff_fff0);
    send_req(ivm_pkg::CMD_ASSIGN, 32'h8000_0000, 32'h7fff_ffff, 8'd65, 0);
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 32'h7fff_ffff);
    drain();
    write_default(8'hff);
    for (int k = 0; k < 40; k++) send_req(ivm_pkg::CMD_ASSIGN, 2 * k, 2 * k + 1, 8'(k), 0);
    send_req(ivm_pkg::CMD_LOOKUP, 0, 0, 0, 3);
    drain();
    write_default(8'd0);
    random_phase(500, 200);
    drain();
    write_default(8'd3);
    random_phase(500, 60);
    drain();
    write_default(8'd65);
    random_phase(500, 0);
    drain();
    if (fail_count == 0) begin
      $display("interval_value_map regression: pass");
    end else begin
      $display("interval_value_map regression: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/ivm_pkg.sv
sv/ivm_if.sv
sv/ivm_ctrl.sv
sv/ivm_dp.sv
sv/interval_value_map.sv
sv/ivm_chk.sv
tb/sv/ivm_checker.sv
tb/sv/interval_value_map_tb.sv
